// File: src/pdr_pkg.sv
// Shared constants for the plane distance and ray hit block.
package pdr_pkg;

    localparam int WORD_W        = 32;
    localparam int NORM_W        = 18;
    localparam int FRAC_BITS_DEF = 16;
    // Sum of three squared 18 bit normals stays below 2^36.
    localparam int NN_W          = 2 * NORM_W;
    localparam int ROOT_W        = NN_W / 2;
    // Dot product of normal and direction: three 50 bit products.
    localparam int DEN_W         = 52;
    localparam int DMAG_W        = DEN_W - 1;
    // Quotient bits kept; a quotient at or above 2^Q_BITS saturates its own result (a parallel ray zeroes the hits).
    localparam int Q_BITS        = 33;
    localparam int FRONT_LAT     = 4;
    localparam int DIST_W        = 31;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NZ     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd3;

endpackage

// File: src/pdr_front.sv
// Front end: dot products, plane value, normal length squared, hit numerators.
module pdr_front import pdr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SMW       = 54,
    parameter int NUMW      = SMW + WORD_W
) (
    input  logic                     clk,
    input  logic                     ce,
    input  logic signed [NORM_W-1:0] nx,
    input  logic signed [NORM_W-1:0] ny,
    input  logic signed [NORM_W-1:0] nz,
    input  logic signed [WORD_W-1:0] offset,
    input  logic signed [WORD_W-1:0] pin [3],
    input  logic signed [WORD_W-1:0] din [3],
    output logic [SMW-1:0]           smag,
    output logic [NUMW-1:0]          num [3],
    output logic [DMAG_W-1:0]        dmag,
    output logic [NN_W-1:0]          nn,
    output logic signed [WORD_W-1:0] pout [3],
    output logic [2:0]               neg,
    output logic                     par
);

    localparam int SW   = SMW + 1;
    localparam int PW   = NORM_W + WORD_W;
    localparam int LOW  = SMW / 2;
    localparam int HIW  = SMW - LOW;

    logic signed [NORM_W-1:0] nv [3];

    // stage A
    logic signed [PW-1:0]     pp_reg [3];
    logic signed [PW-1:0]     dp_reg [3];
    logic signed [NN_W-1:0]   sq_reg [3];
    logic signed [WORD_W-1:0] off_reg;
    logic signed [WORD_W-1:0] pa_reg [3];
    logic signed [WORD_W-1:0] da_reg [3];

    // stage B
    logic signed [SW-1:0]     s_next;
    logic signed [DEN_W-1:0]  den_next;
    logic [SMW-1:0]           smag_b_reg;
    logic [DMAG_W-1:0]        dmag_b_reg;
    logic [NN_W-1:0]          nn_b_reg;
    logic [WORD_W-1:0]        dm_b_reg [3];
    logic [2:0]               neg_b_reg;
    logic                     par_b_reg;
    logic signed [WORD_W-1:0] pb_reg [3];

    // stage C
    logic [LOW+WORD_W-1:0]    lo_reg [3];
    logic [HIW+WORD_W-1:0]    hi_reg [3];
    logic [SMW-1:0]           smag_c_reg;
    logic [DMAG_W-1:0]        dmag_c_reg;
    logic [NN_W-1:0]          nn_c_reg;
    logic [2:0]               neg_c_reg;
    logic                     par_c_reg;
    logic signed [WORD_W-1:0] pc_reg [3];

    // stage D
    logic [NUMW-1:0]          num_reg [3];
    logic [SMW-1:0]           smag_reg;
    logic [DMAG_W-1:0]        dmag_reg;
    logic [NN_W-1:0]          nn_reg;
    logic [2:0]               neg_reg;
    logic                     par_reg;
    logic signed [WORD_W-1:0] pd_reg [3];

    assign nv[0] = nx;
    assign nv[1] = ny;
    assign nv[2] = nz;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i] <= nv[i] * pin[i];
                dp_reg[i] <= nv[i] * din[i];
                sq_reg[i] <= nv[i] * nv[i];
                pa_reg[i] <= pin[i];
                da_reg[i] <= din[i];
            end
            off_reg <= offset;
        end
    end

    always_comb
    begin
        s_next = SW'(pp_reg[0]) + SW'(pp_reg[1]) + SW'(pp_reg[2])
               + (SW'(off_reg) <<< FRAC_BITS);
        den_next = DEN_W'(dp_reg[0]) + DEN_W'(dp_reg[1]) + DEN_W'(dp_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            smag_b_reg <= s_next[SW-1] ? SMW'(-s_next) : SMW'(s_next);
            dmag_b_reg <= den_next[DEN_W-1] ? DMAG_W'(-den_next) : DMAG_W'(den_next);
            nn_b_reg   <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1])
                        + $unsigned(sq_reg[2]);
            par_b_reg  <= (den_next == '0);
            for (int i = 0; i < 3; i++)
            begin
                dm_b_reg[i]  <= da_reg[i][WORD_W-1] ? WORD_W'(-da_reg[i])
                                                    : WORD_W'(da_reg[i]);
                neg_b_reg[i] <= s_next[SW-1] ^ da_reg[i][WORD_W-1] ^ den_next[DEN_W-1];
                pb_reg[i]    <= pa_reg[i];
            end
        end
    end

    // Split the wide magnitude product into two partial products.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= smag_b_reg[LOW-1:0] * dm_b_reg[i];
                hi_reg[i] <= smag_b_reg[SMW-1:LOW] * dm_b_reg[i];
                pc_reg[i] <= pb_reg[i];
            end
            smag_c_reg <= smag_b_reg;
            dmag_c_reg <= dmag_b_reg;
            nn_c_reg   <= nn_b_reg;
            neg_c_reg  <= neg_b_reg;
            par_c_reg  <= par_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= NUMW'(lo_reg[i]) + (NUMW'(hi_reg[i]) << LOW);
                pd_reg[i]  <= pc_reg[i];
            end
            smag_reg <= smag_c_reg;
            dmag_reg <= dmag_c_reg;
            nn_reg   <= nn_c_reg;
            neg_reg  <= neg_c_reg;
            par_reg  <= par_c_reg;
        end
    end

    assign smag = smag_reg;
    assign num  = num_reg;
    assign dmag = dmag_reg;
    assign nn   = nn_reg;
    assign pout = pd_reg;
    assign neg  = neg_reg;
    assign par  = par_reg;

endmodule

// File: src/pdr_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a carried sideband.
module pdr_sqrt import pdr_pkg::*; #(
    parameter int SBW = 1
) (
    input  logic              clk,
    input  logic              ce,
    input  logic [NN_W-1:0]   nn,
    input  logic [SBW-1:0]    sb_in,
    output logic [ROOT_W-1:0] root,
    output logic [SBW-1:0]    sb_out
);

    localparam int RW = ROOT_W + 3;

    logic [NN_W-1:0]   x_reg  [ROOT_W];
    logic [RW-1:0]     r_reg  [ROOT_W];
    logic [ROOT_W-1:0] q_reg  [ROOT_W];
    logic [SBW-1:0]    sb_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [NN_W-1:0]   x_prev;
        logic [RW-1:0]     r_prev;
        logic [ROOT_W-1:0] q_prev;
        logic [SBW-1:0]    sb_prev;
        logic [RW-1:0]     rs;
        logic [RW-1:0]     trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign x_prev  = nn;
            assign r_prev  = '0;
            assign q_prev  = '0;
            assign sb_prev = sb_in;
        end
        else
        begin : g_rest
            assign x_prev  = x_reg[k-1];
            assign r_prev  = r_reg[k-1];
            assign q_prev  = q_reg[k-1];
            assign sb_prev = sb_reg[k-1];
        end

        // bring down the next two bits and try root*4+1
        assign rs    = {r_prev[RW-3:0], x_prev[NN_W-1 -: 2]};
        assign trial = RW'({q_prev, 2'b01});
        assign ge    = (rs >= trial);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                x_reg[k]  <= x_prev << 2;
                r_reg[k]  <= ge ? rs - trial : rs;
                q_reg[k]  <= {q_prev[ROOT_W-2:0], ge};
                sb_reg[k] <= sb_prev;
            end
        end
    end

    assign root   = q_reg[ROOT_W-1];
    assign sb_out = sb_reg[ROOT_W-1];

endmodule

// File: src/pdr_div.sv
// Pipelined restoring divider with overflow check, one quotient bit per stage.
module pdr_div import pdr_pkg::*; #(
    parameter int NUM_W = 64,
    parameter int DIV_W = 32,
    parameter int Q_W   = Q_BITS,
    parameter int SBW   = 1
) (
    input  logic             clk,
    input  logic             ce,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] dvs,
    input  logic [SBW-1:0]   sb_in,
    output logic [Q_W-1:0]   quo,
    output logic             ovf,
    output logic [SBW-1:0]   sb_out
);

    localparam int TOPW = NUM_W - Q_W;
    localparam int CW   = ((TOPW > DIV_W) ? TOPW : DIV_W) + 1;

    logic [DIV_W-1:0] rem0_reg;
    logic [Q_W-1:0]   low0_reg;
    logic [DIV_W-1:0] dvs0_reg;
    logic             ovf0_reg;
    logic [SBW-1:0]   sb0_reg;

    logic [DIV_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];
    logic [DIV_W-1:0] dvs_reg [Q_W];
    logic             ovf_reg [Q_W];
    logic [SBW-1:0]   sb_reg  [Q_W];

    // quotient fits Q_W bits only when the upper numerator part is below the divisor
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ovf0_reg <= (CW'(num[NUM_W-1:Q_W]) >= CW'(dvs));
            rem0_reg <= DIV_W'(num[NUM_W-1:Q_W]);
            low0_reg <= num[Q_W-1:0];
            dvs0_reg <= dvs;
            sb0_reg  <= sb_in;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DIV_W-1:0] rem_prev;
        logic [Q_W-1:0]   low_prev;
        logic [Q_W-1:0]   q_prev;
        logic [DIV_W-1:0] dvs_prev;
        logic             ovf_prev;
        logic [SBW-1:0]   sb_prev;
        logic [DIV_W:0]   t;
        logic [DIV_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_prev = rem0_reg;
            assign low_prev = low0_reg;
            assign q_prev   = '0;
            assign dvs_prev = dvs0_reg;
            assign ovf_prev = ovf0_reg;
            assign sb_prev  = sb0_reg;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign dvs_prev = dvs_reg[k-1];
            assign ovf_prev = ovf_reg[k-1];
            assign sb_prev  = sb_reg[k-1];
        end

        assign t    = {rem_prev, low_prev[Q_W-1]};
        assign diff = t - {1'b0, dvs_prev};
        assign ge   = (t >= {1'b0, dvs_prev});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k] <= ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
                low_reg[k] <= low_prev << 1;
                q_reg[k]   <= {q_prev[Q_W-2:0], ge};
                dvs_reg[k] <= dvs_prev;
                ovf_reg[k] <= ovf_prev;
                sb_reg[k]  <= sb_prev;
            end
        end
    end

    assign quo    = q_reg[Q_W-1];
    assign ovf    = ovf_reg[Q_W-1];
    assign sb_out = sb_reg[Q_W-1];

endmodule

// File: src/plane_distance_and_ray_hit.sv
// Plane distance and ray hit: top level with configuration, valid pipeline and output stage.
// Throughput: one word per cycle while the output is not stalled; the square root and the dividers are fully pipelined.
// A stalled output word holds the whole pipeline until it is taken.
// Reset clears the valid bits and loads the plane z = 0 (normal 0,0,1.0, offset 0).
module plane_distance_and_ray_hit import pdr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_x, point_y, point_z, dir_x, dir_y, dir_z
    input  logic [6*WORD_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // distance, hit_x, hit_y, hit_z, zero pad
    output logic [127:0]         m_tdata,
    // is_parallel, out_of_range
    output logic [1:0]           m_tuser
);

    localparam int SW   = ((WORD_W + FRAC_BITS > 51) ? WORD_W + FRAC_BITS : 51) + 2;
    localparam int SMW  = SW - 1;
    localparam int NUMW = SMW + WORD_W;
    localparam int SBW  = SMW + 3 * NUMW + DMAG_W + 3 * WORD_W + 4;
    localparam int LAT  = FRONT_LAT + ROOT_W + Q_BITS + 2;
    localparam int HW   = Q_BITS + 3;

    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [WORD_W-1:0] off_reg;
    logic [LAT-1:0]           vld_reg;
    logic                     ce;

    logic signed [WORD_W-1:0] pin [3];
    logic signed [WORD_W-1:0] din [3];

    logic [SMW-1:0]           f_smag;
    logic [NUMW-1:0]          f_num [3];
    logic [DMAG_W-1:0]        f_dmag;
    logic [NN_W-1:0]          f_nn;
    logic signed [WORD_W-1:0] f_p [3];
    logic [2:0]               f_neg;
    logic                     f_par;

    logic [SBW-1:0]           sq_sb_in, sq_sb_out;
    logic [ROOT_W-1:0]        norm;

    logic [SMW-1:0]           r_smag;
    logic [NUMW-1:0]          r_num [3];
    logic [DMAG_W-1:0]        r_dmag;
    logic [WORD_W-1:0]        r_p [3];
    logic [2:0]               r_neg;
    logic                     r_par;

    logic [Q_BITS-1:0]        dq;
    logic                     dovf;
    logic                     dpar;
    logic [Q_BITS-1:0]        hq [3];
    logic                     hovf [3];
    logic [WORD_W:0]          hsb [3];

    logic [DIST_W-1:0]        dist_next;
    logic [WORD_W-1:0]        hit_next [3];
    logic                     flag_next;

    logic [DIST_W-1:0]        dist_reg;
    logic [WORD_W-1:0]        hit_reg [3];
    logic                     par_reg;
    logic                     flag_reg;

    assign ce       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= NORM_W'(64'd1 << FRAC_BITS);
            off_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NX:     nx_reg  <= cfg_data[NORM_W-1:0];
                REG_NY:     ny_reg  <= cfg_data[NORM_W-1:0];
                REG_NZ:     nz_reg  <= cfg_data[NORM_W-1:0];
                REG_OFFSET: off_reg <= cfg_data;
                default:    off_reg <= off_reg;
            endcase
        end
    end

    // valid bits advance with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_in
        assign pin[i] = s_tdata[i*WORD_W +: WORD_W];
        assign din[i] = s_tdata[(i+3)*WORD_W +: WORD_W];
    end

    pdr_front #(
        .FRAC_BITS (FRAC_BITS),
        .SMW       (SMW),
        .NUMW      (NUMW)
    ) u_front (
        .clk    (clk),
        .ce     (ce),
        .nx     (nx_reg),
        .ny     (ny_reg),
        .nz     (nz_reg),
        .offset (off_reg),
        .pin    (pin),
        .din    (din),
        .smag   (f_smag),
        .num    (f_num),
        .dmag   (f_dmag),
        .nn     (f_nn),
        .pout   (f_p),
        .neg    (f_neg),
        .par    (f_par)
    );

    assign sq_sb_in = {f_par, f_neg, f_p[2], f_p[1], f_p[0], f_dmag,
                       f_num[2], f_num[1], f_num[0], f_smag};

    pdr_sqrt #(
        .SBW (SBW)
    ) u_sqrt (
        .clk    (clk),
        .ce     (ce),
        .nn     (f_nn),
        .sb_in  (sq_sb_in),
        .root   (norm),
        .sb_out (sq_sb_out)
    );

    assign {r_par, r_neg, r_p[2], r_p[1], r_p[0], r_dmag,
            r_num[2], r_num[1], r_num[0], r_smag} = sq_sb_out;

    pdr_div #(
        .NUM_W (SMW),
        .DIV_W (ROOT_W),
        .Q_W   (Q_BITS),
        .SBW   (1)
    ) u_div_dist (
        .clk    (clk),
        .ce     (ce),
        .num    (r_smag),
        .dvs    (norm),
        .sb_in  (r_par),
        .quo    (dq),
        .ovf    (dovf),
        .sb_out (dpar)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_hit
        pdr_div #(
            .NUM_W (NUMW),
            .DIV_W (DMAG_W),
            .Q_W   (Q_BITS),
            .SBW   (WORD_W + 1)
        ) u_div_hit (
            .clk    (clk),
            .ce     (ce),
            .num    (r_num[i]),
            .dvs    (r_dmag),
            .sb_in  ({r_neg[i], r_p[i]}),
            .quo    (hq[i]),
            .ovf    (hovf[i]),
            .sb_out (hsb[i])
        );
    end

    always_comb
    begin
        logic [HW-1:0]        qm;
        logic signed [HW-1:0] t;
        logic signed [HW-1:0] h;

        flag_next = 1'b0;
        if (dovf || (dq[Q_BITS-1:DIST_W] != '0))
        begin
            dist_next = '1;
            flag_next = 1'b1;
        end
        else
        begin
            dist_next = dq[DIST_W-1:0];
        end

        for (int i = 0; i < 3; i++)
        begin
            // clamp the quotient; any clamped value saturates the hit anyway
            qm = hovf[i] ? (HW'(1) << Q_BITS) : HW'(hq[i]);
            t  = hsb[i][WORD_W] ? -$signed(qm) : $signed(qm);
            h  = HW'($signed(hsb[i][WORD_W-1:0])) - t;
            if (dpar)
            begin
                hit_next[i] = '0;
            end
            else if (h > HW'(32'sh7FFF_FFFF))
            begin
                hit_next[i] = 32'h7FFF_FFFF;
                flag_next   = 1'b1;
            end
            else if (h < -HW'(33'sh0_8000_0000))
            begin
                hit_next[i] = 32'h8000_0000;
                flag_next   = 1'b1;
            end
            else
            begin
                hit_next[i] = h[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dist_reg <= dist_next;
            hit_reg  <= hit_next;
            par_reg  <= dpar;
            flag_reg <= flag_next;
        end
    end

    assign m_tdata = {1'b0, hit_reg[2], hit_reg[1], hit_reg[0], dist_reg};
    assign m_tuser = {flag_reg, par_reg};

endmodule
